/* rtl/core/tpcal_pkg.sv */
// ----------------------------------------------------------------------------
// Three-point touch calibration package
// Shared widths, register indexes and transaction types of the solver.
// ----------------------------------------------------------------------------
`default_nettype none

package tpcal_pkg;

	localparam int RAW_BITS      = 12;  // raw touch sample width
	localparam int CFG_BITS      = 12;  // screen size register width
	localparam int CFG_IDX_BITS  = 8;
	localparam int COEF_BITS     = 32;  // Q-format coefficient width
	localparam int NUM_COEF      = 6;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [CFG_BITS-1:0] WIDTH_RST  = CFG_BITS'(320);
	localparam logic [CFG_BITS-1:0] HEIGHT_RST = CFG_BITS'(240);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SCREEN_WIDTH  = 8'd0,
		REG_SCREEN_HEIGHT = 8'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [RAW_BITS-1:0] raw_x_first;
		logic [RAW_BITS-1:0] raw_y_first;
		logic [RAW_BITS-1:0] raw_x_second;
		logic [RAW_BITS-1:0] raw_y_second;
		logic [RAW_BITS-1:0] raw_x_third;
		logic [RAW_BITS-1:0] raw_y_third;
	} sample_t;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] gain_x_from_raw_x;
		logic signed [COEF_BITS-1:0] gain_x_from_raw_y;
		logic signed [COEF_BITS-1:0] offset_x;
		logic signed [COEF_BITS-1:0] gain_y_from_raw_x;
		logic signed [COEF_BITS-1:0] gain_y_from_raw_y;
		logic signed [COEF_BITS-1:0] offset_y;
		logic                        degenerate;
		logic                        saturated;
	} coef_t;

endpackage

`default_nettype wire

/* rtl/core/touch_three_point_calibration_solver.sv */
// ----------------------------------------------------------------------------
// Three-point touchscreen calibration solver
// Solves the affine raw-to-screen map from three touch samples by Cramer's
// rule and delivers six rounded, saturated Q-format coefficients.
// ----------------------------------------------------------------------------
// The solver accepts one transaction of three raw samples per clock while
// it is not halted and returns one coefficient transaction for each, in
// order. Five stages form the differences, products, determinant and the six
// cofactors, one stage takes magnitudes and checks for overflow, and then a
// restoring divider develops one quotient bit per stage (the 32 result bits
// plus one rounding bit) for all six coefficients side by side. The last
// stage rounds half away from zero, clips to the signed 32-bit range and
// holds the result until it is taken. The whole pipeline advances together;
// it halts only while a finished result waits and the sink is not ready.
// Calibration targets are derived from the screen size registers with
// shifts, since 25, 50 and 75 percent with truncation equal w/4, h/2 and
// 3w/4. The size registers may only change while no transaction is in
// flight. A zero determinant gives zero coefficients with degenerate set.
`default_nettype none

module touch_three_point_calibration_solver
	import tpcal_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire  [CFG_IDX_BITS-1:0] cfg_index,
	input  wire  [CFG_BITS-1:0]     cfg_data,
	input  wire                     sample_valid,
	output logic                    sample_ready,
	input  wire  sample_t           sample,
	output logic                    coef_valid,
	input  wire                     coef_ready,
	output coef_t                   coef
);

	localparam int RB  = RAW_BITS;
	localparam int CW  = CFG_BITS;
	localparam int PW  = RB + CW + 2;        // difference product width
	localparam int CPW = 2 * RB + 1;         // raw cross product, signed
	localparam int MW  = CW + 1 + CPW;       // target times cofactor
	localparam int DW  = 2 * RB + 3;         // determinant width
	localparam int NW  = MW + 2;             // numerator width
	localparam int QB  = COEF_BITS + 1;      // quotient bits incl. rounding bit
	localparam int LB  = COEF_BITS - FRAC_BITS;
	localparam int NST = 5 + QB + 2;         // valid stages

	// Configuration registers.
	logic [CW-1:0] width_q, height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Screen targets; target three shares its X with target two.
	logic [CW+1:0] w3, h3;
	logic [CW-1:0] tx1, tx2, ty1, ty2, ty3;

	assign w3  = {2'b00, width_q} + {1'b0, width_q, 1'b0};
	assign h3  = {2'b00, height_q} + {1'b0, height_q, 1'b0};
	assign tx1 = {2'b00, width_q[CW-1:2]};
	assign tx2 = w3[CW+1:2];
	assign ty1 = {1'b0, height_q[CW-1:1]};
	assign ty2 = {2'b00, height_q[CW-1:2]};
	assign ty3 = h3[CW+1:2];

	// The pipeline moves as one unit whenever the output register is free.
	logic            en;
	logic [NST-1:0]  vld;

	assign en           = !vld[NST-1] || coef_ready;
	assign sample_ready = en;
	assign coef_valid   = vld[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (en) begin
			vld <= {vld[NST-2:0], sample_valid};
		end
	end

	// Stage 1: differences of raw samples and of targets.
	logic signed [RB:0] dx13_s1, dx23_s1, dy13_s1, dy23_s1;
	logic signed [CW:0] tx13_s1, tx23_s1, ty13_s1, ty23_s1;
	logic [RB-1:0]      rx1_s1, ry1_s1, rx2_s1, ry2_s1, rx3_s1, ry3_s1;
	logic [CW-1:0]      tx1_s1, tx2_s1, ty1_s1, ty2_s1, ty3_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx13_s1 <= $signed({1'b0, sample.raw_x_first}) - $signed({1'b0, sample.raw_x_third});
			dx23_s1 <= $signed({1'b0, sample.raw_x_second}) - $signed({1'b0, sample.raw_x_third});
			dy13_s1 <= $signed({1'b0, sample.raw_y_first}) - $signed({1'b0, sample.raw_y_third});
			dy23_s1 <= $signed({1'b0, sample.raw_y_second}) - $signed({1'b0, sample.raw_y_third});
			tx13_s1 <= $signed({1'b0, tx1}) - $signed({1'b0, tx2});
			tx23_s1 <= '0;
			ty13_s1 <= $signed({1'b0, ty1}) - $signed({1'b0, ty3});
			ty23_s1 <= $signed({1'b0, ty2}) - $signed({1'b0, ty3});
			rx1_s1  <= sample.raw_x_first;
			ry1_s1  <= sample.raw_y_first;
			rx2_s1  <= sample.raw_x_second;
			ry2_s1  <= sample.raw_y_second;
			rx3_s1  <= sample.raw_x_third;
			ry3_s1  <= sample.raw_y_third;
			tx1_s1  <= tx1;
			tx2_s1  <= tx2;
			ty1_s1  <= ty1;
			ty2_s1  <= ty2;
			ty3_s1  <= ty3;
		end
	end

	// Stage 2: all two-term products.
	logic signed [2*RB+1:0] pda_s2, pdb_s2;
	logic [2*RB-1:0]        c23a_s2, c23b_s2, c13a_s2, c13b_s2, c12a_s2, c12b_s2;
	logic signed [PW-1:0]   n0a_s2, n0b_s2, n1a_s2, n1b_s2;
	logic signed [PW-1:0]   n3a_s2, n3b_s2, n4a_s2, n4b_s2;
	logic [CW-1:0]          tx1_s2, tx2_s2, ty1_s2, ty2_s2, ty3_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pda_s2  <= dx13_s1 * dy23_s1;
			pdb_s2  <= dx23_s1 * dy13_s1;
			c23a_s2 <= rx2_s1 * ry3_s1;
			c23b_s2 <= rx3_s1 * ry2_s1;
			c13a_s2 <= rx1_s1 * ry3_s1;
			c13b_s2 <= rx3_s1 * ry1_s1;
			c12a_s2 <= rx1_s1 * ry2_s1;
			c12b_s2 <= rx2_s1 * ry1_s1;
			n0a_s2  <= tx13_s1 * dy23_s1;
			n0b_s2  <= tx23_s1 * dy13_s1;
			n1a_s2  <= dx13_s1 * tx23_s1;
			n1b_s2  <= dx23_s1 * tx13_s1;
			n3a_s2  <= ty13_s1 * dy23_s1;
			n3b_s2  <= ty23_s1 * dy13_s1;
			n4a_s2  <= dx13_s1 * ty23_s1;
			n4b_s2  <= dx23_s1 * ty13_s1;
			tx1_s2  <= tx1_s1;
			tx2_s2  <= tx2_s1;
			ty1_s2  <= ty1_s1;
			ty2_s2  <= ty2_s1;
			ty3_s2  <= ty3_s1;
		end
	end

	// Stage 3: determinant, raw cofactors and the simple numerators.
	logic signed [DW-1:0]  det_s3;
	logic signed [CPW-1:0] c23_s3, c13_s3, c12_s3;
	logic signed [PW:0]    n0_s3, n1_s3, n3_s3, n4_s3;
	logic [CW-1:0]         tx1_s3, tx2_s3, ty1_s3, ty2_s3, ty3_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			det_s3 <= DW'(pda_s2) - DW'(pdb_s2);
			c23_s3 <= $signed({1'b0, c23a_s2}) - $signed({1'b0, c23b_s2});
			c13_s3 <= $signed({1'b0, c13a_s2}) - $signed({1'b0, c13b_s2});
			c12_s3 <= $signed({1'b0, c12a_s2}) - $signed({1'b0, c12b_s2});
			n0_s3  <= (PW+1)'(n0a_s2) - (PW+1)'(n0b_s2);
			n1_s3  <= (PW+1)'(n1a_s2) - (PW+1)'(n1b_s2);
			n3_s3  <= (PW+1)'(n3a_s2) - (PW+1)'(n3b_s2);
			n4_s3  <= (PW+1)'(n4a_s2) - (PW+1)'(n4b_s2);
			tx1_s3 <= tx1_s2;
			tx2_s3 <= tx2_s2;
			ty1_s3 <= ty1_s2;
			ty2_s3 <= ty2_s2;
			ty3_s3 <= ty3_s2;
		end
	end

	// Stage 4: target-weighted cofactors for the offsets.
	logic signed [MW-1:0] mx1_s4, mx2_s4, mx3_s4, my1_s4, my2_s4, my3_s4;
	logic signed [DW-1:0] det_s4;
	logic signed [PW:0]   n0_s4, n1_s4, n3_s4, n4_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			mx1_s4 <= $signed({1'b0, tx1_s3}) * c23_s3;
			mx2_s4 <= $signed({1'b0, tx2_s3}) * c13_s3;
			mx3_s4 <= $signed({1'b0, tx2_s3}) * c12_s3;
			my1_s4 <= $signed({1'b0, ty1_s3}) * c23_s3;
			my2_s4 <= $signed({1'b0, ty2_s3}) * c13_s3;
			my3_s4 <= $signed({1'b0, ty3_s3}) * c12_s3;
			det_s4 <= det_s3;
			n0_s4  <= n0_s3;
			n1_s4  <= n1_s3;
			n3_s4  <= n3_s3;
			n4_s4  <= n4_s3;
		end
	end

	// Stage 5: all six numerators, in output order.
	logic signed [NW-1:0] num_s5 [NUM_COEF];
	logic signed [DW-1:0] det_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5[0] <= NW'(n0_s4);
			num_s5[1] <= NW'(n1_s4);
			num_s5[2] <= NW'(mx1_s4) - NW'(mx2_s4) + NW'(mx3_s4);
			num_s5[3] <= NW'(n3_s4);
			num_s5[4] <= NW'(n4_s4);
			num_s5[5] <= NW'(my1_s4) - NW'(my2_s4) + NW'(my3_s4);
			det_s5    <= det_s4;
		end
	end

	// Divider setup: magnitudes, result signs and the integer-part overflow.
	logic [NW-1:0] un   [NUM_COEF];
	logic [NW-1:0] uhi  [NUM_COEF];
	logic [DW-1:0] ud;

	always_comb begin
		ud = det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
		for (int c = 0; c < NUM_COEF; c++) begin
			un[c]  = num_s5[c][NW-1] ? NW'(-num_s5[c]) : NW'(num_s5[c]);
			uhi[c] = un[c] >> LB;
		end
	end

	// Divider stage k holds the partial remainder after k quotient bits.
	logic [DW-1:0] rem_d  [QB+1][NUM_COEF];
	logic [QB-1:0] quo_d  [QB+1][NUM_COEF];
	logic [LB-1:0] low_d  [QB+1][NUM_COEF];
	logic          neg_d  [QB+1][NUM_COEF];
	logic          ovf_d  [QB+1][NUM_COEF];
	logic [DW-1:0] ud_d   [QB+1];
	logic          zero_d [QB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			ud_d[0]   <= ud;
			zero_d[0] <= (det_s5 == '0);
			for (int c = 0; c < NUM_COEF; c++) begin
				rem_d[0][c] <= uhi[c][DW-1:0];
				quo_d[0][c] <= '0;
				low_d[0][c] <= un[c][LB-1:0];
				neg_d[0][c] <= num_s5[c][NW-1] ^ det_s5[DW-1];
				ovf_d[0][c] <= (uhi[c] >= NW'(ud));
			end
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		logic          nbit [NUM_COEF];
		logic [DW:0]   trial [NUM_COEF];
		logic          take [NUM_COEF];

		always_comb begin
			for (int c = 0; c < NUM_COEF; c++) begin
				// Numerator bits below the fraction point are zero.
				nbit[c]  = (k < LB) ? low_d[k][c][(k < LB) ? (LB - 1 - k) : 0] : 1'b0;
				trial[c] = {rem_d[k][c], nbit[c]};
				take[c]  = (trial[c] >= {1'b0, ud_d[k]});
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ud_d[k+1]   <= ud_d[k];
				zero_d[k+1] <= zero_d[k];
				for (int c = 0; c < NUM_COEF; c++) begin
					rem_d[k+1][c] <= take[c] ? DW'(trial[c] - {1'b0, ud_d[k]})
					                         : trial[c][DW-1:0];
					quo_d[k+1][c] <= {quo_d[k][c][QB-2:0], take[c]};
					low_d[k+1][c] <= low_d[k][c];
					neg_d[k+1][c] <= neg_d[k][c];
					ovf_d[k+1][c] <= ovf_d[k][c];
				end
			end
		end
	end

	// Output stage: round half away from zero, clip, apply sign.
	logic [QB:0]           rnd   [NUM_COEF];
	logic [QB-1:0]         mag   [NUM_COEF];
	logic [QB-1:0]         limit [NUM_COEF];
	logic                  clip  [NUM_COEF];
	logic [COEF_BITS-1:0]  mclip [NUM_COEF];
	logic [COEF_BITS-1:0]  res   [NUM_COEF];
	logic                  any_clip;
	coef_t                 degen_coef;

	always_comb begin
		any_clip = 1'b0;
		for (int c = 0; c < NUM_COEF; c++) begin
			rnd[c]   = {1'b0, quo_d[QB][c]} + (QB+1)'(1);
			mag[c]   = rnd[c][QB:1];
			limit[c] = neg_d[QB][c] ? (QB'(1) << (COEF_BITS - 1))
			                        : ((QB'(1) << (COEF_BITS - 1)) - QB'(1));
			clip[c]  = ovf_d[QB][c] || (mag[c] > limit[c]);
			mclip[c] = clip[c] ? limit[c][COEF_BITS-1:0] : mag[c][COEF_BITS-1:0];
			res[c]   = neg_d[QB][c] ? (~mclip[c] + COEF_BITS'(1)) : mclip[c];
			any_clip = any_clip | clip[c];
		end
	end

	// Result for a zero determinant: all coefficients zero, degenerate set.
	always_comb begin
		degen_coef            = '0;
		degen_coef.degenerate = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_d[QB]) begin
				coef <= degen_coef;
			end else begin
				coef.gain_x_from_raw_x <= res[0];
				coef.gain_x_from_raw_y <= res[1];
				coef.offset_x          <= res[2];
				coef.gain_y_from_raw_x <= res[3];
				coef.gain_y_from_raw_y <= res[4];
				coef.offset_y          <= res[5];
				coef.degenerate        <= 1'b0;
				coef.saturated         <= any_clip;
			end
		end
	end

endmodule

`default_nettype wire
